>>> rtl/cmdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdq_pkg
// Shared types and constants for the command queue retry engine.
// ----------------------------------------------------------------------------
package cmdq_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int CMD_W  = 5;
    localparam int BYTE_W = 8;
    localparam int RETRY_W = 3;
    localparam int QCNT_W = 5;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
    localparam logic [OP_W-1:0] OP_PLAY      = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLY     = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd3;
    localparam logic [OP_W-1:0] OP_BUSY_FELL = 3'd4;

    // Player command ids with special handling
    localparam logic [CMD_W-1:0] CMD_IDLE         = 5'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY_STATUS = 5'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY         = 5'd3;
    localparam logic [CMD_W-1:0] CMD_STOP         = 5'd4;

    // Reply bytes
    localparam logic [BYTE_W-1:0] REPLY_ERROR  = 8'h45;  // 'E'
    localparam logic [BYTE_W-1:0] REPLY_STATUS = 8'h53;  // 'S'

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0]  TIMEOUT_RESET = 8'd100;
    localparam logic [RETRY_W-1:0] RETRY_RESET   = 3'd3;

    // Ring write/pop request from the engine
    typedef struct packed {
        logic             push_en;
        logic [CMD_W-1:0] push_data;
        logic             pop_en;
    } ring_req_t;

    // One result item
    typedef struct packed {
        logic              issue_valid;
        logic [CMD_W-1:0]  issue_command;
        logic              done_valid;
        logic [CMD_W-1:0]  done_command;
        logic              reply_error;
        logic              timed_out;
        logic              playing;
        logic [QCNT_W-1:0] queue_count;
    } result_t;

endpackage

>>> rtl/command_queue_retry_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_queue_retry_engine_top
// Queues player command ids and issues them one at a time with timeout and
// retry; one result per request.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  s_        s_valid / s_ready     s_op, s_command, s_reply_first_byte
//  m_        m_valid / m_ready     m_issue_*, m_done_*, m_reply_error,
//                                  m_timed_out, m_playing, m_queue_count
//  cfg_      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
//  One request per cycle unless a result stalls; each result is held in the output register until taken.
//  A play request while playing takes a STOP pass and a PLAY pass: the ring has a single
//  write port and that request pushes STOP and PLAY.
//  The ring needs no clearing after reset; aresetn is synchronous, active low.
//  A stalled result holds in the output register while the input register
//  still takes the next request.
// ----------------------------------------------------------------------------
module command_queue_retry_engine_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cmdq_pkg::OP_W-1:0]     s_op,
    input  logic [cmdq_pkg::CMD_W-1:0]    s_command,
    input  logic [cmdq_pkg::BYTE_W-1:0]   s_reply_first_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_issue_valid,
    output logic [cmdq_pkg::CMD_W-1:0]    m_issue_command,
    output logic                          m_done_valid,
    output logic [cmdq_pkg::CMD_W-1:0]    m_done_command,
    output logic                          m_reply_error,
    output logic                          m_timed_out,
    output logic                          m_playing,
    output logic [cmdq_pkg::QCNT_W-1:0]   m_queue_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [cmdq_pkg::BYTE_W-1:0]   cfg_data
);
    import cmdq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

    logic              in_valid_reg, in_valid_next;
    logic [OP_W-1:0]   op_reg;
    logic [CMD_W-1:0]  command_reg;
    logic [BYTE_W-1:0] reply_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic              fire;
    logic              step_done;
    logic              s_accept;
    result_t           result;
    ring_req_t         ring_req;
    logic [PTR_W-1:0]  ring_count;
    logic [CMD_W-1:0]  head_data;

    // Handshake control
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_done;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step_done) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_done) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request, load the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg         <= s_op;
            command_reg    <= s_command;
            reply_byte_reg <= s_reply_first_byte;
        end
        if (step_done) begin
            out_reg <= result;
        end
    end

    cmdq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ring_req),
        .count     (ring_count),
        .head_data (head_data)
    );

    cmdq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (fire),
        .op         (op_reg),
        .command    (command_reg),
        .reply_byte (reply_byte_reg),
        .ring_count (ring_count),
        .head_data  (head_data),
        .ring_req   (ring_req),
        .step_done  (step_done),
        .result     (result)
    );

    assign m_valid         = out_valid_reg;
    assign m_issue_valid   = out_reg.issue_valid;
    assign m_issue_command = out_reg.issue_command;
    assign m_done_valid    = out_reg.done_valid;
    assign m_done_command  = out_reg.done_command;
    assign m_reply_error   = out_reg.reply_error;
    assign m_timed_out     = out_reg.timed_out;
    assign m_playing       = out_reg.playing;
    assign m_queue_count   = out_reg.queue_count;

endmodule

>>> rtl/cmdq_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdq_ring
// Command id ring: one write port at the tail, registered read of the head
// entry with a write bypass, and head/tail pointers with the fill count.
// ----------------------------------------------------------------------------
module cmdq_ring #(
    parameter int QUEUE_DEPTH = 32,
    parameter int PTR_W       = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cmdq_pkg::ring_req_t           req,
    output logic [PTR_W-1:0]              count,
    output logic [cmdq_pkg::CMD_W-1:0]    head_data
);
    import cmdq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(QUEUE_DEPTH);

    logic [CMD_W-1:0] ring_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CMD_W-1:0] rd_data_reg;
    logic             byp_valid_reg, byp_valid_next;
    logic [CMD_W-1:0] byp_data_reg;
    logic [PTR_W:0]   count_wide;

    // Advance pointers with wrap at the ring depth
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (req.pop_en) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
        end
        if (req.push_en) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
        end
        byp_valid_next = req.push_en && (tail_reg == head_next);
    end

    // Fill count from the pointer distance
    always_comb begin
        if (tail_reg >= head_reg) begin
            count_wide = {1'b0, tail_reg} - {1'b0, head_reg};
        end else begin
            count_wide = {1'b0, tail_reg} + DEPTH_W - {1'b0, head_reg};
        end
    end

    assign count     = count_wide[PTR_W-1:0];
    assign head_data = byp_valid_reg ? byp_data_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    // Write at the tail, prefetch the entry at the next head
    always_ff @(posedge aclk) begin
        if (req.push_en) begin
            ring_mem[tail_reg] <= req.push_data;
        end
        rd_data_reg  <= ring_mem[head_next];
        byp_data_reg <= req.push_data;
    end

    // Never write into a full ring
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push_en |-> (count != LAST_PTR))
        else $error("ring push while full");

    // Never pop an empty ring unless this cycle supplies the entry
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop_en |-> (count != '0 || req.push_en))
        else $error("ring pop while empty");

    // Pointers only meet again when the ring drains
    a_ptr_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.push_en && !req.pop_en) |=> (tail_reg != head_reg))
        else $error("ring pointers collided on push");

endmodule

>>> rtl/cmdq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdq_engine
// Per-request control: push filtering, reply and timeout handling, retries,
// playing flag, and issue of the next queued command when idle.
// ----------------------------------------------------------------------------
module cmdq_engine #(
    parameter int QUEUE_DEPTH = 32,
    parameter int PTR_W       = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [cmdq_pkg::BYTE_W-1:0]   cfg_data,
    input  logic                          fire,
    input  logic [cmdq_pkg::OP_W-1:0]     op,
    input  logic [cmdq_pkg::CMD_W-1:0]    command,
    input  logic [cmdq_pkg::BYTE_W-1:0]   reply_byte,
    input  logic [PTR_W-1:0]              ring_count,
    input  logic [cmdq_pkg::CMD_W-1:0]    head_data,
    output cmdq_pkg::ring_req_t           ring_req,
    output logic                          step_done,
    output cmdq_pkg::result_t             result
);
    import cmdq_pkg::*;

    localparam logic [PTR_W-1:0] FULL_CNT = PTR_W'(QUEUE_DEPTH - 1);

    logic [BYTE_W-1:0]  timeout_ticks_reg;
    logic [RETRY_W-1:0] retry_limit_reg;
    logic [CMD_W-1:0]   last_pushed_reg, last_pushed_next;
    logic [CMD_W-1:0]   cur_reg, cur_next;
    logic [BYTE_W-1:0]  timeout_left_reg, timeout_left_next;
    logic [RETRY_W-1:0] retries_left_reg, retries_left_next;
    logic               playing_reg, playing_next;
    logic               phase_reg, phase_next;

    logic               is_split;
    logic               push_req;
    logic               push_new;
    logic               push_en;
    logic [CMD_W-1:0]   push_id;
    logic [PTR_W-1:0]   count_ap;
    logic [PTR_W-1:0]   count_final;
    logic [31:0]        count_ext;
    logic [BYTE_W-1:0]  tl_dec;
    logic [RETRY_W-1:0] rl_dec;
    logic [CMD_W-1:0]   pop_id;

    // Push selection: a play request while playing splits into a STOP pass
    always_comb begin
        is_split = (op == OP_PLAY) && playing_reg && !phase_reg;
        push_req = (op == OP_PUSH) || (op == OP_PLAY);
        if (op == OP_PUSH) begin
            push_id = command;
        end else if (is_split) begin
            push_id = CMD_STOP;
        end else begin
            push_id = CMD_PLAY;
        end
        push_new = push_req && (push_id != last_pushed_reg);
        push_en  = push_new && (ring_count != FULL_CNT);
        count_ap = ring_count + PTR_W'(push_en);
        pop_id   = (ring_count == '0) ? push_id : head_data;
        tl_dec   = timeout_left_reg - BYTE_W'(1);
        rl_dec   = retries_left_reg - RETRY_W'(1);
    end

    // Step logic
    always_comb begin
        last_pushed_next  = last_pushed_reg;
        cur_next          = cur_reg;
        timeout_left_next = timeout_left_reg;
        retries_left_next = retries_left_reg;
        playing_next      = playing_reg;
        phase_next        = phase_reg;
        ring_req          = '0;
        step_done         = 1'b0;
        result            = '0;
        count_final       = ring_count;

        if (fire) begin
            if (push_new) begin
                last_pushed_next = push_id;
            end
            ring_req.push_en   = push_en;
            ring_req.push_data = push_id;
            count_final        = count_ap;

            if (is_split) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                step_done  = 1'b1;

                case (op)
                    OP_REPLY: begin
                        if (reply_byte == REPLY_ERROR) begin
                            result.reply_error = 1'b1;
                        end else if (cur_reg == CMD_QUERY_STATUS &&
                                     reply_byte == REPLY_STATUS) begin
                            playing_next = 1'b0;
                        end
                        if (cur_reg != CMD_IDLE) begin
                            result.done_valid   = 1'b1;
                            result.done_command = cur_reg;
                        end
                        cur_next = CMD_IDLE;
                    end
                    OP_TICK: begin
                        if (cur_reg != CMD_IDLE) begin
                            timeout_left_next = tl_dec;
                            if (tl_dec == '0) begin
                                result.timed_out  = 1'b1;
                                retries_left_next = rl_dec;
                                if (rl_dec != '0) begin
                                    // resend the outstanding command
                                    if (cur_reg == CMD_PLAY) begin
                                        playing_next = 1'b1;
                                    end
                                    timeout_left_next    = timeout_ticks_reg;
                                    result.issue_valid   = 1'b1;
                                    result.issue_command = cur_reg;
                                end else begin
                                    cur_next = CMD_IDLE;
                                end
                            end
                        end
                    end
                    OP_BUSY_FELL: begin
                        playing_next = 1'b0;
                    end
                    default: begin
                    end
                endcase

                // Pop the next id when idle; issue it unless it is the idle id
                if (cur_next == CMD_IDLE && count_ap != '0) begin
                    ring_req.pop_en = 1'b1;
                    count_final     = count_ap - PTR_W'(1);
                    if (count_ap == PTR_W'(1)) begin
                        last_pushed_next = CMD_IDLE;
                    end
                    cur_next = pop_id;
                    if (pop_id != CMD_IDLE) begin
                        retries_left_next = retry_limit_reg;
                        if (pop_id == CMD_PLAY) begin
                            playing_next = 1'b1;
                        end
                        timeout_left_next    = timeout_ticks_reg;
                        result.issue_valid   = 1'b1;
                        result.issue_command = pop_id;
                    end
                end
            end
        end

        count_ext          = 32'(count_final);
        result.playing     = playing_next;
        result.queue_count = count_ext[QCNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pushed_reg  <= CMD_IDLE;
            cur_reg          <= CMD_IDLE;
            timeout_left_reg <= '0;
            retries_left_reg <= '0;
            playing_reg      <= 1'b0;
            phase_reg        <= 1'b0;
        end else begin
            last_pushed_reg  <= last_pushed_next;
            cur_reg          <= cur_next;
            timeout_left_reg <= timeout_left_next;
            retries_left_reg <= retries_left_next;
            playing_reg      <= playing_next;
            phase_reg        <= phase_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RESET;
            retry_limit_reg   <= RETRY_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_TIMEOUT) begin
                timeout_ticks_reg <= cfg_data;
            end else begin
                retry_limit_reg <= cfg_data[RETRY_W-1:0];
            end
        end
    end

    // The STOP pass only ever belongs to a held play request
    a_split_play: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (op == OP_PLAY))
        else $error("split pass on a non-play request");

    // After the STOP pass the request always finishes on the next fire
    a_split_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg && fire) |-> step_done)
        else $error("split request did not finish");

    // An issued command is never the idle id
    a_issue_nonidle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_done && result.issue_valid) |-> (result.issue_command != CMD_IDLE))
        else $error("idle id issued");

    // Timeouts only come from ticks
    a_timeout_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_done && result.timed_out) |-> (op == OP_TICK))
        else $error("timeout outside a tick");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command queue retry engine. A scoreboard class
// keeps its own copy of the ring, the busy command, the timeout and retry
// counters and the playing flag, and predicts one result per accepted
// request. Directed requests cover the edge cases, then random phases under
// several register settings fill the ring, force timeouts and mix replies,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
    import cmdq_pkg::*;

    typedef enum {
        MODE_FILL,
        MODE_TIMEOUT,
        MODE_MIXED
    } traffic_mode_e;

    // Predicts engine behavior and checks results in order
    class engine_scoreboard;
        logic [BYTE_W-1:0]  timeout_ticks;
        logic [RETRY_W-1:0] retry_limit;
        logic [CMD_W-1:0]   ring_mem [32];
        logic [4:0]         rd_ptr;
        logic [4:0]         wr_ptr;
        logic [CMD_W-1:0]   last_id;
        logic [CMD_W-1:0]   active_id;
        logic [BYTE_W-1:0]  ticks_left;
        logic [RETRY_W-1:0] tries_left;
        logic               playing;
        result_t            outcome_q [$];
        int                 failures;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            retry_limit   = RETRY_RESET;
            rd_ptr        = '0;
            wr_ptr        = '0;
            last_id       = CMD_IDLE;
            active_id     = CMD_IDLE;
            ticks_left    = '0;
            tries_left    = '0;
            playing       = 1'b0;
            failures      = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_config(logic idx, logic [BYTE_W-1:0] data);
            if (idx == CFG_TIMEOUT) begin
                timeout_ticks = data;
            end else begin
                retry_limit = data[RETRY_W-1:0];
            end
        endfunction

        // Ring depth 32: the 5-bit pointer difference is the fill level
        function logic [4:0] waiting();
            return wr_ptr - rd_ptr;
        endfunction

        // Drop repeats; a full ring drops the id but still remembers it
        function void enqueue_id(logic [CMD_W-1:0] id);
            if (id == last_id) return;
            if (waiting() < 5'd31) begin
                ring_mem[wr_ptr] = id;
                wr_ptr = wr_ptr + 5'd1;
            end
            last_id = id;
        endfunction

        function void send_active();
            if (active_id == CMD_PLAY) playing = 1'b1;
            ticks_left = timeout_ticks;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [CMD_W-1:0] cmd,
                                   logic [BYTE_W-1:0] rb);
            result_t          r;
            logic [CMD_W-1:0] id;
            r = '0;
            case (op)
                OP_PUSH: begin
                    enqueue_id(cmd);
                end
                OP_PLAY: begin
                    if (playing) enqueue_id(CMD_STOP);
                    enqueue_id(CMD_PLAY);
                end
                OP_REPLY: begin
                    if (rb == REPLY_ERROR) begin
                        r.reply_error = 1'b1;
                    end else if (active_id == CMD_QUERY_STATUS && rb == REPLY_STATUS) begin
                        playing = 1'b0;
                    end
                    if (active_id != CMD_IDLE) begin
                        r.done_valid   = 1'b1;
                        r.done_command = active_id;
                    end
                    active_id = CMD_IDLE;
                end
                OP_TICK: begin
                    if (active_id != CMD_IDLE) begin
                        ticks_left = ticks_left - 8'd1;
                        if (ticks_left == 0) begin
                            r.timed_out = 1'b1;
                            tries_left  = tries_left - 3'd1;
                            if (tries_left != 0) begin
                                send_active();
                                r.issue_valid   = 1'b1;
                                r.issue_command = active_id;
                            end else begin
                                active_id = CMD_IDLE;
                            end
                        end
                    end
                end
                OP_BUSY_FELL: begin
                    playing = 1'b0;
                end
                default: ;
            endcase

            // Pop the next id when idle; id zero is consumed without an issue
            if (active_id == CMD_IDLE && waiting() != 0) begin
                id     = ring_mem[rd_ptr];
                rd_ptr = rd_ptr + 5'd1;
                if (rd_ptr == wr_ptr) last_id = CMD_IDLE;
                active_id = id;
                if (id != CMD_IDLE) begin
                    tries_left = retry_limit;
                    send_active();
                    r.issue_valid   = 1'b1;
                    r.issue_command = id;
                end
            end
            r.playing     = playing;
            r.queue_count = waiting();
            outcome_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            string   bad;
            if (outcome_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result with no request pending");
                return;
            end
            want = outcome_q.pop_front();
            bad  = "";
            if (got.issue_valid   !== want.issue_valid)   bad = {bad, " issue_valid"};
            if (got.issue_command !== want.issue_command) bad = {bad, " issue_command"};
            if (got.done_valid    !== want.done_valid)    bad = {bad, " done_valid"};
            if (got.done_command  !== want.done_command)  bad = {bad, " done_command"};
            if (got.reply_error   !== want.reply_error)   bad = {bad, " reply_error"};
            if (got.timed_out     !== want.timed_out)     bad = {bad, " timed_out"};
            if (got.playing       !== want.playing)       bad = {bad, " playing"};
            if (got.queue_count   !== want.queue_count)   bad = {bad, " queue_count"};
            if (bad != "") begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch at %0t on%s", $realtime, bad);
                    $display("  expected issue %0b/%0d done %0b/%0d err %0b tout %0b play %0b cnt %0d",
                             want.issue_valid, want.issue_command, want.done_valid,
                             want.done_command, want.reply_error, want.timed_out,
                             want.playing, want.queue_count);
                    $display("  actual   issue %0b/%0d done %0b/%0d err %0b tout %0b play %0b cnt %0d",
                             got.issue_valid, got.issue_command, got.done_valid,
                             got.done_command, got.reply_error, got.timed_out,
                             got.playing, got.queue_count);
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = OP_PUSH;
    logic [CMD_W-1:0]    s_command = CMD_IDLE;
    logic [BYTE_W-1:0]   s_reply_first_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_issue_valid;
    logic [CMD_W-1:0]    m_issue_command;
    logic                m_done_valid;
    logic [CMD_W-1:0]    m_done_command;
    logic                m_reply_error;
    logic                m_timed_out;
    logic                m_playing;
    logic [QCNT_W-1:0]   m_queue_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_TIMEOUT;
    logic [BYTE_W-1:0]   cfg_data = '0;

    engine_scoreboard    sb;
    bit                  no_gaps = 1'b0;

    command_queue_retry_engine_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_command          (s_command),
        .s_reply_first_byte (s_reply_first_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_issue_valid      (m_issue_valid),
        .m_issue_command    (m_issue_command),
        .m_done_valid       (m_done_valid),
        .m_done_command     (m_done_command),
        .m_reply_error      (m_reply_error),
        .m_timed_out        (m_timed_out),
        .m_playing          (m_playing),
        .m_queue_count      (m_queue_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hold off for a random gap, then present one request until it is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] cmd,
                                input logic [BYTE_W-1:0] rb);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_op               <= op;
        s_command          <= cmd;
        s_reply_first_byte <= rb;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(op, cmd, rb);
    endtask

    // Drain all results, then give the pipeline time to settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Write both registers back to back
    task automatic configure(input logic [BYTE_W-1:0] timeout, input logic [RETRY_W-1:0] retry);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.note_config(CFG_TIMEOUT, timeout);
        cfg_index <= CFG_RETRY;
        cfg_data  <= {5'd0, retry};
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.note_config(CFG_RETRY, {5'd0, retry});
        cfg_valid <= 1'b0;
    endtask

    // Draw one request, weighted by the traffic mode of the phase
    task automatic pick_request(input traffic_mode_e mode, output logic [OP_W-1:0] op,
                                output logic [CMD_W-1:0] cmd, output logic [BYTE_W-1:0] rb);
        int roll;
        int push_w, play_w, reply_w, tick_w, busy_w;
        case (mode)
            MODE_FILL:    begin push_w = 70; play_w = 8;  reply_w = 8;  tick_w = 8;  busy_w = 3; end
            MODE_TIMEOUT: begin push_w = 20; play_w = 8;  reply_w = 10; tick_w = 55; busy_w = 4; end
            default:      begin push_w = 35; play_w = 10; reply_w = 25; tick_w = 20; busy_w = 5; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < push_w) begin
            op = OP_PUSH;
        end else if (roll < push_w + play_w) begin
            op = OP_PLAY;
        end else if (roll < push_w + play_w + reply_w) begin
            op = OP_REPLY;
        end else if (roll < push_w + play_w + reply_w + tick_w) begin
            op = OP_TICK;
        end else if (roll < push_w + play_w + reply_w + tick_w + busy_w) begin
            op = OP_BUSY_FELL;
        end else begin
            op = OP_W'($urandom_range(5, 7));
        end

        // Favor the ids with special handling
        case ($urandom_range(0, 7))
            0:       cmd = CMD_QUERY_STATUS;
            1:       cmd = CMD_PLAY;
            2:       cmd = CMD_STOP;
            3:       cmd = CMD_IDLE;
            default: cmd = CMD_W'($urandom_range(0, 31));
        endcase

        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            rb = REPLY_ERROR;
        end else if (roll < 6) begin
            rb = REPLY_STATUS;
        end else begin
            rb = BYTE_W'($urandom_range(0, 255));
        end
    endtask

    // Result side: random stalls, check every accepted result
    initial begin : result_sink
        int      gap;
        result_t got;
        wait (aresetn === 1'b1);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.issue_valid   = m_issue_valid;
            got.issue_command = m_issue_command;
            got.done_valid    = m_done_valid;
            got.done_command  = m_done_command;
            got.reply_error   = m_reply_error;
            got.timed_out     = m_timed_out;
            got.playing       = m_playing;
            got.queue_count   = m_queue_count;
            sb.check_result(got);
        end
    end

    // Stimulus: directed edge cases, then random phases under several settings
    initial begin : stimulus
        logic [OP_W-1:0]    op;
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  rb;
        logic [BYTE_W-1:0]  timeout;
        logic [RETRY_W-1:0] retry;
        traffic_mode_e      mode;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short timeout so expiry, resend and give-up all show up
        configure(8'd2, 3'd2);
        send_request(OP_PUSH, CMD_IDLE, 8'h00);          // zero repeats the empty memory
        send_request(OP_PUSH, 5'd31, 8'hFF);             // unknown id, issued at once
        repeat (2) send_request(OP_TICK, 5'd0, 8'h00);   // expire and resend
        repeat (2) send_request(OP_TICK, 5'd31, 8'hFF);  // retries spent, give up
        send_request(OP_PUSH, CMD_QUERY_STATUS, 8'h00);
        send_request(OP_PLAY, 5'd0, 8'h00);
        send_request(OP_PLAY, 5'd0, 8'h00);              // repeated play is dropped
        send_request(OP_REPLY, 5'd0, REPLY_STATUS);      // playing starts on issue
        send_request(OP_PLAY, 5'd0, 8'h00);              // stop then play
        send_request(OP_PUSH, CMD_IDLE, 8'h00);          // zero id queued
        send_request(OP_PUSH, CMD_QUERY_STATUS, 8'h00);
        send_request(OP_REPLY, 5'd0, REPLY_ERROR);
        send_request(OP_REPLY, 5'd31, 8'h00);
        send_request(OP_REPLY, 5'd0, REPLY_STATUS);      // pops the zero id
        send_request(OP_BUSY_FELL, 5'd0, 8'h00);
        send_request(OP_REPLY, 5'd0, REPLY_STATUS);      // status reply to the query while not playing
        send_request(OP_REPLY, 5'd0, REPLY_ERROR);       // error while idle
        send_request(OP_TICK, 5'd0, 8'h00);              // tick while idle
        send_request(3'd5, 5'd0, 8'h00);
        send_request(3'd6, 5'd31, 8'hFF);
        send_request(3'd7, 5'd0, 8'h00);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       begin timeout = 8'd255; retry = 3'd7; end
                1:       begin timeout = 8'd1;   retry = 3'd1; end
                2:       begin timeout = 8'd0;   retry = 3'd0; end
                3:       begin timeout = 8'd100; retry = 3'd3; end
                4:       begin timeout = 8'd1;   retry = 3'd7; end
                default: begin
                    timeout = BYTE_W'($urandom_range(1, 8));
                    retry   = RETRY_W'($urandom_range(1, 7));
                end
            endcase
            mode = traffic_mode_e'(ph % 3);
            quiesce();
            configure(timeout, retry);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (103) begin
                // toggle back-to-back stretches now and then
                if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
                pick_request(mode, op, cmd, rb);
                send_request(op, cmd, rb);
            end
        end

        quiesce();
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Bound the run
    initial begin : watchdog
        #500_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> command_queue_retry_engine_top.f
rtl/cmdq_pkg.sv
rtl/cmdq_ring.sv
rtl/cmdq_engine.sv
rtl/command_queue_retry_engine_top.sv
tb/tb.sv
